FILE: design/erm_pkg.sv
// Shared constants, types and tables of the Euler-angle to rotation-matrix block
`timescale 1ns / 1ps

package erm_pkg;

   // Angle and output formats
   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OUT_W      = FRAC_BITS + 2;

   // Internal Q30 arithmetic
   localparam int Q30_FRAC = 30;
   localparam int Z_W      = Q30_FRAC + 1;     // unsigned Q30 up to and including 1.0
   localparam int SIN_W    = Q30_FRAC + 2;     // signed Q30 in [-1.0, 1.0]
   localparam int PROD_W   = 2 * SIN_W;        // signed Q60 products and sums

   // Pipeline shape
   localparam int HORNER_STEPS = 6;
   localparam int SIN_STAGES   = HORNER_STEPS + 2;
   localparam int MAT_STAGES   = 5;
   localparam int PIPE_STAGES  = SIN_STAGES + MAT_STAGES;

   // Matrix entries, row-major
   localparam int N_ENT    = 9;
   localparam int IDX_R0C0 = 0;
   localparam int IDX_R0C1 = 1;
   localparam int IDX_R0C2 = 2;
   localparam int IDX_R1C0 = 3;
   localparam int IDX_R1C1 = 4;
   localparam int IDX_R1C2 = 5;
   localparam int IDX_R2C0 = 6;
   localparam int IDX_R2C1 = 7;
   localparam int IDX_R2C2 = 8;

   typedef logic [ANGLE_BITS-1:0]     erm_angle_type;
   typedef logic signed [SIN_W-1:0]   erm_sin_type;
   typedef logic signed [OUT_W-1:0]   erm_entry_type;

   localparam erm_angle_type QUARTER_TURN = erm_angle_type'(1) << (ANGLE_BITS - 2);

   // Taylor coefficients of sin(pi/2 * z) in Q30, for z^1, z^3, ..., z^13
   localparam logic [Z_W-1:0] SIN_COEF [HORNER_STEPS+1] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
      31'd172272, 31'd3864, 31'd61
   };

   // Per-stage advance enables handed from the control to the datapaths
   typedef struct packed {
      logic [MAT_STAGES-1:0] mat_en;
      logic [SIN_STAGES-1:0] sin_en;
   } erm_adv_type;

endpackage

FILE: design/erm_if.sv
// Valid/ready channel interfaces for angle transactions and matrix transactions
`timescale 1ns / 1ps

interface erm_req_if import erm_pkg::*; ();
   logic          valid;
   logic          ready;
   erm_angle_type yaw_angle;
   erm_angle_type pitch_angle;
   erm_angle_type roll_angle;

   modport source (output valid, output yaw_angle, output pitch_angle, output roll_angle,
                   input ready);
   modport sink   (input valid, input yaw_angle, input pitch_angle, input roll_angle,
                   output ready);
endinterface

interface erm_rsp_if import erm_pkg::*; ();
   logic          valid;
   logic          ready;
   erm_entry_type m_r0_c0;
   erm_entry_type m_r0_c1;
   erm_entry_type m_r0_c2;
   erm_entry_type m_r1_c0;
   erm_entry_type m_r1_c1;
   erm_entry_type m_r1_c2;
   erm_entry_type m_r2_c0;
   erm_entry_type m_r2_c1;
   erm_entry_type m_r2_c2;

   modport source (output valid, input ready,
                   output m_r0_c0, output m_r0_c1, output m_r0_c2,
                   output m_r1_c0, output m_r1_c1, output m_r1_c2,
                   output m_r2_c0, output m_r2_c1, output m_r2_c2);
   modport sink   (input valid, output ready,
                   input m_r0_c0, input m_r0_c1, input m_r0_c2,
                   input m_r1_c0, input m_r1_c1, input m_r1_c2,
                   input m_r2_c0, input m_r2_c1, input m_r2_c2);
endinterface

FILE: design/erm_sin_lane.sv
// One pipelined sine lane: quadrant fold, z squared, Horner steps, final product
`timescale 1ns / 1ps

module erm_sin_lane import erm_pkg::*; (
   input  logic                  clock,
   input  logic [SIN_STAGES-1:0] stage_en,
   input  erm_angle_type         angle,
   output erm_sin_type           sine
);

   localparam int             Z_SHIFT = 32 - ANGLE_BITS;
   localparam logic [Z_W-1:0] Q30_ONE = Z_W'(1) << Q30_FRAC;

   // Stage registers
   logic [Z_W-1:0] z2_ff [HORNER_STEPS];
   logic [Z_W-1:0] z_ff  [HORNER_STEPS+1];
   logic [1:0]     q_ff  [HORNER_STEPS+1];
   logic [Z_W-1:0] h_ff  [HORNER_STEPS];
   erm_sin_type    sine_ff;

   // Fold the angle into the first quadrant and square it
   logic [1:0]       quad;
   logic [Z_W-1:0]   z_raw;
   logic [Z_W-1:0]   z_in;
   logic [2*Z_W-1:0] zz;

   always_comb begin
      quad  = angle[ANGLE_BITS-1 -: 2];
      z_raw = Z_W'(angle[ANGLE_BITS-3:0]) << Z_SHIFT;
      z_in  = quad[0] ? (Q30_ONE - z_raw) : z_raw;
      zz    = (2*Z_W)'(z_in) * (2*Z_W)'(z_in);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         z2_ff[0] <= zz[Q30_FRAC +: Z_W];
         z_ff[0]  <= z_in;
         q_ff[0]  <= quad;
      end
   end

   // Horner steps, one coefficient per stage
   for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
      logic [Z_W-1:0]   h_prev;
      logic [2*Z_W-1:0] prod;
      logic [Z_W-1:0]   h_in;

      if (j == 0) begin : g_first
         assign h_prev = SIN_COEF[HORNER_STEPS];
      end else begin : g_next
         assign h_prev = h_ff[j-1];
      end

      assign prod = (2*Z_W)'(h_prev) * (2*Z_W)'(z2_ff[j]);
      assign h_in = SIN_COEF[HORNER_STEPS-1-j] - prod[Q30_FRAC +: Z_W];

      always_ff @(posedge clock) begin
         if (stage_en[j+1]) begin
            h_ff[j]   <= h_in;
            z_ff[j+1] <= z_ff[j];
            q_ff[j+1] <= q_ff[j];
         end
      end

      // z squared only travels as far as the last Horner step
      if (j < HORNER_STEPS - 1) begin : g_z2
         always_ff @(posedge clock) begin
            if (stage_en[j+1]) begin
               z2_ff[j+1] <= z2_ff[j];
            end
         end
      end
   end

   // Final multiply by z, clamp to 1.0 and apply the half-turn sign
   logic [2*Z_W-1:0] s_prod;
   logic [Z_W-1:0]   s_mag;
   logic [Z_W-1:0]   s_clamp;
   erm_sin_type      sine_in;

   always_comb begin
      s_prod  = (2*Z_W)'(h_ff[HORNER_STEPS-1]) * (2*Z_W)'(z_ff[HORNER_STEPS]);
      s_mag   = s_prod[Q30_FRAC +: Z_W];
      s_clamp = (s_mag > Q30_ONE) ? Q30_ONE : s_mag;
      sine_in = q_ff[HORNER_STEPS][1] ? -$signed(SIN_W'(s_clamp)) : $signed(SIN_W'(s_clamp));
   end

   always_ff @(posedge clock) begin
      if (stage_en[SIN_STAGES-1]) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

FILE: design/erm_matrix.sv
// Matrix datapath: double products, Q30 rounding, triple products, sums, final rounding
`timescale 1ns / 1ps

module erm_matrix import erm_pkg::*; (
   input  logic                  clock,
   input  logic [MAT_STAGES-1:0] stage_en,
   input  erm_sin_type           sy,
   input  erm_sin_type           cy,
   input  erm_sin_type           sp,
   input  erm_sin_type           cp,
   input  erm_sin_type           sr,
   input  erm_sin_type           cr,
   output erm_entry_type         m_ent [N_ENT]
);

   localparam int FIN_SHIFT = 2 * Q30_FRAC - FRAC_BITS;

   typedef logic signed [PROD_W-1:0] erm_prod_type;

   typedef struct packed {
      erm_prod_type cpcy;
      erm_prod_type cpsy;
      erm_prod_type srcp;
      erm_prod_type crcp;
      erm_prod_type crsy;
      erm_prod_type crcy;
      erm_prod_type srsy;
      erm_prod_type srcy;
   } erm_dbl_type;

   // Q60 to Q30, nearest, ties away from zero
   function automatic erm_sin_type rnd_q30(input erm_prod_type x);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] rnd;
      erm_sin_type       r;
      mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
      rnd = (mag + (PROD_W'(1) << (Q30_FRAC - 1))) >> Q30_FRAC;
      r   = $signed(SIN_W'(rnd));
      return x[PROD_W-1] ? -r : r;
   endfunction

   // Q60 to output format, nearest, ties away from zero, saturated to +/- 1.0
   function automatic erm_entry_type fin_entry(input erm_prod_type x);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] rnd;
      erm_entry_type     r;
      mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
      rnd = (mag + (PROD_W'(1) << (FIN_SHIFT - 1))) >> FIN_SHIFT;
      if (rnd > (PROD_W'(1) << FRAC_BITS)) begin
         rnd = PROD_W'(1) << FRAC_BITS;
      end
      r = $signed(OUT_W'(rnd));
      return x[PROD_W-1] ? -r : r;
   endfunction

   // Stage 1: all two-factor products
   erm_dbl_type  dbl1_ff;
   erm_prod_type srsp_raw_ff;
   erm_prod_type crsp_raw_ff;
   erm_sin_type  sp1_ff;
   erm_sin_type  cy1_ff;
   erm_sin_type  sy1_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dbl1_ff.cpcy <= PROD_W'(cp) * PROD_W'(cy);
         dbl1_ff.cpsy <= PROD_W'(cp) * PROD_W'(sy);
         dbl1_ff.srcp <= PROD_W'(sr) * PROD_W'(cp);
         dbl1_ff.crcp <= PROD_W'(cr) * PROD_W'(cp);
         dbl1_ff.crsy <= PROD_W'(cr) * PROD_W'(sy);
         dbl1_ff.crcy <= PROD_W'(cr) * PROD_W'(cy);
         dbl1_ff.srsy <= PROD_W'(sr) * PROD_W'(sy);
         dbl1_ff.srcy <= PROD_W'(sr) * PROD_W'(cy);
         srsp_raw_ff  <= PROD_W'(sr) * PROD_W'(sp);
         crsp_raw_ff  <= PROD_W'(cr) * PROD_W'(sp);
         sp1_ff       <= sp;
         cy1_ff       <= cy;
         sy1_ff       <= sy;
      end
   end

   // Stage 2: round the inner products of the triple terms back to Q30
   erm_dbl_type dbl2_ff;
   erm_sin_type srsp_ff;
   erm_sin_type crsp_ff;
   erm_sin_type sp2_ff;
   erm_sin_type cy2_ff;
   erm_sin_type sy2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         dbl2_ff <= dbl1_ff;
         srsp_ff <= rnd_q30(srsp_raw_ff);
         crsp_ff <= rnd_q30(crsp_raw_ff);
         sp2_ff  <= sp1_ff;
         cy2_ff  <= cy1_ff;
         sy2_ff  <= sy1_ff;
      end
   end

   // Stage 3: triple products
   erm_dbl_type  dbl3_ff;
   erm_prod_type srspcy_ff;
   erm_prod_type srspsy_ff;
   erm_prod_type crspcy_ff;
   erm_prod_type crspsy_ff;
   erm_sin_type  sp3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         dbl3_ff   <= dbl2_ff;
         srspcy_ff <= PROD_W'(srsp_ff) * PROD_W'(cy2_ff);
         srspsy_ff <= PROD_W'(srsp_ff) * PROD_W'(sy2_ff);
         crspcy_ff <= PROD_W'(crsp_ff) * PROD_W'(cy2_ff);
         crspsy_ff <= PROD_W'(crsp_ff) * PROD_W'(sy2_ff);
         sp3_ff    <= sp2_ff;
      end
   end

   // Stage 4: entry sums in Q60
   erm_prod_type sum_ff [N_ENT];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sum_ff[IDX_R0C0] <= dbl3_ff.cpcy;
         sum_ff[IDX_R0C1] <= dbl3_ff.cpsy;
         sum_ff[IDX_R0C2] <= -(PROD_W'(sp3_ff) <<< Q30_FRAC);
         sum_ff[IDX_R1C0] <= srspcy_ff - dbl3_ff.crsy;
         sum_ff[IDX_R1C1] <= srspsy_ff + dbl3_ff.crcy;
         sum_ff[IDX_R1C2] <= dbl3_ff.srcp;
         sum_ff[IDX_R2C0] <= crspcy_ff + dbl3_ff.srsy;
         sum_ff[IDX_R2C1] <= crspsy_ff - dbl3_ff.srcy;
         sum_ff[IDX_R2C2] <= dbl3_ff.crcp;
      end
   end

   // Stage 5: round and saturate each entry; this is the output register
   erm_entry_type ent_ff [N_ENT];

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int i = 0; i < N_ENT; i++) begin
            ent_ff[i] <= fin_entry(sum_ff[i]);
         end
      end
   end

   assign m_ent = ent_ff;

endmodule

FILE: design/erm_ctrl.sv
// Pipeline control: per-stage valid bits and stall enables with bubble collapse
`timescale 1ns / 1ps

module erm_ctrl import erm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output erm_adv_type adv
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] stage_en;
   logic [PIPE_STAGES-1:0] shifted;

   // A stage may load when it, or any stage after it, holds a bubble, or the output drains
   always_comb begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         stage_en[k] = rsp_ready |
                       ~&(valid_ff | ((PIPE_STAGES'(1) << k) - PIPE_STAGES'(1)));
      end
      shifted  = {valid_ff[PIPE_STAGES-2:0], req_valid};
      valid_in = (stage_en & shifted) | (~stage_en & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready  = stage_en[0];
   assign rsp_valid  = valid_ff[PIPE_STAGES-1];
   assign adv.sin_en = stage_en[SIN_STAGES-1:0];
   assign adv.mat_en = stage_en[PIPE_STAGES-1:SIN_STAGES];

endmodule

FILE: design/euler_to_rotation_matrix.sv
// Top level: yaw/pitch/roll binary angles to the ZYX direction cosine matrix
`timescale 1ns / 1ps
//
//  channel   direction  handshake        payload
//  req_ch    in         valid / ready    yaw_angle, pitch_angle, roll_angle (16 b binary angle)
//  rsp_ch    out        valid / ready    m_r0_c0 .. m_r2_c2 (16 b signed Q2.14)
//
//  One transaction per cycle sustained while rsp_ch is ready; 8 sine stages, set by the
//  Horner chain of six registered multiplies, then 5 matrix stages.
//  Synchronous reset clears the valid bits only; datapath registers are not reset.
//  A stall at rsp_ch freezes only the stages behind the full ones, so bubbles close up
//  and req_ch keeps accepting while any stage is empty.

module euler_to_rotation_matrix import erm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   erm_req_if.sink   req_ch,
   erm_rsp_if.source rsp_ch
);

   localparam int N_LANES = 6;
   localparam int LANE_SY = 0;
   localparam int LANE_CY = 1;
   localparam int LANE_SP = 2;
   localparam int LANE_CP = 3;
   localparam int LANE_SR = 4;
   localparam int LANE_CR = 5;

   erm_adv_type   adv;
   erm_angle_type lane_angle [N_LANES];
   erm_sin_type   lane_sin   [N_LANES];
   erm_entry_type m_ent      [N_ENT];

   // Control
   erm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .adv       (adv)
   );

   // Cosine is the sine a quarter turn on
   always_comb begin
      lane_angle[LANE_SY] = req_ch.yaw_angle;
      lane_angle[LANE_CY] = req_ch.yaw_angle + QUARTER_TURN;
      lane_angle[LANE_SP] = req_ch.pitch_angle;
      lane_angle[LANE_CP] = req_ch.pitch_angle + QUARTER_TURN;
      lane_angle[LANE_SR] = req_ch.roll_angle;
      lane_angle[LANE_CR] = req_ch.roll_angle + QUARTER_TURN;
   end

   // Six sine lanes in lockstep
   for (genvar i = 0; i < N_LANES; i++) begin : g_lane
      erm_sin_lane u_lane (
         .clock    (clock),
         .stage_en (adv.sin_en),
         .angle    (lane_angle[i]),
         .sine     (lane_sin[i])
      );
   end

   // Products, sums and final rounding
   erm_matrix u_matrix (
      .clock    (clock),
      .stage_en (adv.mat_en),
      .sy       (lane_sin[LANE_SY]),
      .cy       (lane_sin[LANE_CY]),
      .sp       (lane_sin[LANE_SP]),
      .cp       (lane_sin[LANE_CP]),
      .sr       (lane_sin[LANE_SR]),
      .cr       (lane_sin[LANE_CR]),
      .m_ent    (m_ent)
   );

   assign rsp_ch.m_r0_c0 = m_ent[IDX_R0C0];
   assign rsp_ch.m_r0_c1 = m_ent[IDX_R0C1];
   assign rsp_ch.m_r0_c2 = m_ent[IDX_R0C2];
   assign rsp_ch.m_r1_c0 = m_ent[IDX_R1C0];
   assign rsp_ch.m_r1_c1 = m_ent[IDX_R1C1];
   assign rsp_ch.m_r1_c2 = m_ent[IDX_R1C2];
   assign rsp_ch.m_r2_c0 = m_ent[IDX_R2C0];
   assign rsp_ch.m_r2_c1 = m_ent[IDX_R2C1];
   assign rsp_ch.m_r2_c2 = m_ent[IDX_R2C2];

endmodule

FILE: design/erm_checker.sv
// Port-level checker for the rotation-matrix block, bound to the top level
`timescale 1ns / 1ps

module erm_checker import erm_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [N_ENT-1:0][OUT_W-1:0] rsp_entries
);

   localparam int CNT_W = $clog2(PIPE_STAGES + 2);

   // Transactions in flight
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             req_acc;
   logic             rsp_acc;

   always_comb begin
      req_acc = req_valid && req_ready;
      rsp_acc = rsp_valid && rsp_ready;
      cnt_in  = cnt_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Every entry within +/- 1.0
   logic in_range;

   always_comb begin
      in_range = 1'b1;
      for (int i = 0; i < N_ENT; i++) begin
         if ($signed(rsp_entries[i]) > $signed(OUT_W'(1) << FRAC_BITS) ||
             $signed(rsp_entries[i]) < -$signed(OUT_W'(1) << FRAC_BITS)) begin
            in_range = 1'b0;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entries))
      else $error("result changed or vanished while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range)
      else $error("matrix entry beyond unit magnitude");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(PIPE_STAGES))
      else $error("more transactions in flight than pipeline stages");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result offered with no transaction in flight");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind euler_to_rotation_matrix erm_checker u_erm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_entries ({rsp_ch.m_r2_c2, rsp_ch.m_r2_c1, rsp_ch.m_r2_c0,
                  rsp_ch.m_r1_c2, rsp_ch.m_r1_c1, rsp_ch.m_r1_c0,
                  rsp_ch.m_r0_c2, rsp_ch.m_r0_c1, rsp_ch.m_r0_c0})
);

FILE: tb/euler_to_rotation_matrix_tb.sv
// Self-checking testbench of the yaw/pitch/roll to rotation matrix block
`timescale 1ns / 1ps

module euler_to_rotation_matrix_tb;
   import erm_pkg::*;

   localparam int  QUIET_TAIL   = 200;      // last angle sets are sent without gaps or stalls
   localparam int  RANDOM_SETS  = 1430;
   localparam int  HOLD_OFF_AT  = 300;      // accepted sets before the long receiver hold-off
   localparam int  HOLD_OFF_LEN = 120;
   localparam int  DRAIN_AT     = 700;      // set that waits for an empty pipeline

   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   // Taylor terms of sin(pi/2 * z) in unsigned Q30, z^1 up to z^13
   localparam longint unsigned TAYLOR_Q30 [7] = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
      64'd172272, 64'd3864, 64'd61
   };

   typedef logic [N_ENT-1:0][OUT_W-1:0] dcm_entries_type;

   typedef struct {
      erm_angle_type yaw;
      erm_angle_type pitch;
      erm_angle_type roll;
      bit            after_drain;
      bit            quiet;
   } angle_set_type;

   logic clock;
   logic reset;

   erm_req_if req_ch ();
   erm_rsp_if rsp_ch ();

   angle_set_type   angle_queue [$];
   dcm_entries_type matrix_expected [$];

   int  error_count    = 0;
   int  accepted_count = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   bit  quiet_phase    = 1'b0;
   bit  hold_off       = 1'b0;

   string entry_name [N_ENT] = '{"m_r0_c0", "m_r0_c1", "m_r0_c2",
                                 "m_r1_c0", "m_r1_c1", "m_r1_c2",
                                 "m_r2_c0", "m_r2_c1", "m_r2_c2"};

   euler_to_rotation_matrix dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 50 MHz clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Fixed-point sine of a binary angle, signed Q30
   function automatic longint signed sine_q30(input erm_angle_type ang);
      longint unsigned z, z2, h, s;
      logic [1:0]      quadrant;
      quadrant = ang[ANGLE_BITS-1 -: 2];
      z = 64'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      if (quadrant[0])
         z = Q30_ONE - z;
      z2 = (z * z) >> 30;
      h  = TAYLOR_Q30[6];
      for (int i = 5; i >= 0; i--)
         h = TAYLOR_Q30[i] - ((h * z2) >> 30);
      s = (h * z) >> 30;
      if (s > Q30_ONE)
         s = Q30_ONE;
      return quadrant[1] ? -$signed(s) : $signed(s);
   endfunction

   // Divide by 2^k, nearest, ties away from zero
   function automatic longint signed round_away(input longint signed x, input int k);
      longint unsigned mag;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      if (k > 0)
         mag = (mag + (64'd1 << (k - 1))) >> k;
      return (x < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   // Q60 sum to a saturated output entry
   function automatic erm_entry_type q60_to_entry(input longint signed q60);
      longint signed v, lim;
      lim = longint'(1) <<< FRAC_BITS;
      v   = round_away(q60, 60 - FRAC_BITS);
      if (v > lim)
         v = lim;
      if (v < -lim)
         v = -lim;
      return erm_entry_type'(v);
   endfunction

   // Direction cosine matrix of one angle set
   function automatic dcm_entries_type predict_matrix(input angle_set_type a);
      longint signed sy, cy, sp, cp, sr, cr, srsp, crsp;
      dcm_entries_type m;
      sy   = sine_q30(a.yaw);
      cy   = sine_q30(a.yaw + QUARTER_TURN);
      sp   = sine_q30(a.pitch);
      cp   = sine_q30(a.pitch + QUARTER_TURN);
      sr   = sine_q30(a.roll);
      cr   = sine_q30(a.roll + QUARTER_TURN);
      srsp = round_away(sr * sp, 30);
      crsp = round_away(cr * sp, 30);
      m[IDX_R0C0] = q60_to_entry(cp * cy);
      m[IDX_R0C1] = q60_to_entry(cp * sy);
      m[IDX_R0C2] = q60_to_entry(-(sp <<< 30));
      m[IDX_R1C0] = q60_to_entry(srsp * cy - cr * sy);
      m[IDX_R1C1] = q60_to_entry(srsp * sy + cr * cy);
      m[IDX_R1C2] = q60_to_entry(sr * cp);
      m[IDX_R2C0] = q60_to_entry(crsp * cy + sr * sy);
      m[IDX_R2C1] = q60_to_entry(crsp * sy - sr * cy);
      m[IDX_R2C2] = q60_to_entry(cr * cp);
      return m;
   endfunction

   // Random angle: mostly uniform, some close to quadrant and octant boundaries
   function automatic erm_angle_type pick_angle();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 70)
         return erm_angle_type'($urandom);
      return erm_angle_type'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 6) - 3);
   endfunction

   // Driver: offers queued angle sets, predicts each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            matrix_expected.push_back(predict_matrix(angle_queue[0]));
            void'(angle_queue.pop_front());
            accepted_count++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered transaction
         end else if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (angle_queue.size() == 0 ||
                      (angle_queue[0].after_drain && matrix_expected.size() != 0)) begin
            req_ch.valid <= 1'b0;
         end else if (!angle_queue[0].quiet && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 7);
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid       <= 1'b1;
            req_ch.yaw_angle   <= angle_queue[0].yaw;
            req_ch.pitch_angle <= angle_queue[0].pitch;
            req_ch.roll_angle  <= angle_queue[0].roll;
            quiet_phase        <= angle_queue[0].quiet;
         end
      end
   end

   // Monitor: checks each matrix transaction, drives ready with random stalls
   always @(posedge clock) begin : check_proc
      dcm_entries_type exp_m, got_m;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_m[IDX_R0C0] = rsp_ch.m_r0_c0;
            got_m[IDX_R0C1] = rsp_ch.m_r0_c1;
            got_m[IDX_R0C2] = rsp_ch.m_r0_c2;
            got_m[IDX_R1C0] = rsp_ch.m_r1_c0;
            got_m[IDX_R1C1] = rsp_ch.m_r1_c1;
            got_m[IDX_R1C2] = rsp_ch.m_r1_c2;
            got_m[IDX_R2C0] = rsp_ch.m_r2_c0;
            got_m[IDX_R2C1] = rsp_ch.m_r2_c1;
            got_m[IDX_R2C2] = rsp_ch.m_r2_c2;
            if (matrix_expected.size() == 0) begin
               $error("matrix transaction with no angle set outstanding");
               error_count++;
            end else begin
               exp_m = matrix_expected.pop_front();
               for (int i = 0; i < N_ENT; i++) begin
                  if (got_m[i] !== exp_m[i]) begin
                     $error("%s: expected %0d, got %0d", entry_name[i],
                            $signed(exp_m[i]), $signed(got_m[i]));
                     error_count++;
                  end
               end
            end
         end
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off so the pipeline fills and back-pressures the input
   initial begin
      wait (accepted_count >= HOLD_OFF_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus, reset and end of run
   initial begin : main_proc
      erm_angle_type corner [12];
      angle_set_type a;

      corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                 16'hFFFF, 16'h3FFF, 16'h4001, 16'h7FFF,
                 16'hBFFF, 16'hC001, 16'h2000, 16'h0001};

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.yaw_angle   = '0;
      req_ch.pitch_angle = '0;
      req_ch.roll_angle  = '0;
      rsp_ch.ready       = 1'b0;

      // Directed: quadrant edges, mirror points near the sine peak, gimbal lock
      for (int i = 0; i < 20; i++) begin
         a.yaw         = corner[i % 12];
         a.pitch       = corner[(i * 5 + 3) % 12];
         a.roll        = corner[(i * 7 + 1) % 12];
         a.after_drain = 1'b0;
         a.quiet       = 1'b0;
         angle_queue.push_back(a);
      end

      // Random angle sets
      for (int i = 0; i < RANDOM_SETS; i++) begin
         a.yaw         = pick_angle();
         a.pitch       = pick_angle();
         a.roll        = pick_angle();
         a.after_drain = (i == 0) || (i == DRAIN_AT);
         a.quiet       = (i >= RANDOM_SETS - QUIET_TAIL);
         angle_queue.push_back(a);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (angle_queue.size() != 0 || matrix_expected.size() != 0);
      repeat (PIPE_STAGES + 20) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
